[rtl/core/iibs_pkg.sv]
`timescale 1ns / 1ps

package iibs_pkg;

	// Largest image the table can hold.
	localparam int unsigned MAX_COLS = 256;
	localparam int unsigned MAX_ROWS = 256;

	localparam int unsigned COL_W  = $clog2(MAX_COLS);
	localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
	localparam int unsigned CW     = $clog2(MAX_COLS + 1);
	localparam int unsigned RW     = $clog2(MAX_ROWS + 1);
	localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	localparam int unsigned SIZE_W   = 9;
	localparam int unsigned SUM_W    = 24;
	localparam int unsigned ROWSUM_W = 16;

	localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIX_WR,
		ST_QRY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] pixel;
		logic [7:0] left_col;
		logic [7:0] top_row;
		logic [7:0] right_col;
		logic [7:0] bottom_row;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] box_sum;
		logic             bad_rect;
	} result_t;

	// Table entry (row, col) sits at row * MAX_COLS + col.
	function automatic logic [ADDR_W-1:0] addr_of(input int unsigned row,
		input int unsigned col);
		return ADDR_W'(row * MAX_COLS + col);
	endfunction

	// A size of zero acts as one; anything above the maximum acts as the maximum.
	function automatic logic [CW-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return CW'(1);
		end
		if (32'(v) > MAX_COLS) begin
			return CW'(MAX_COLS);
		end
		return CW'(v);
	endfunction

	function automatic logic [RW-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return RW'(1);
		end
		if (32'(v) > MAX_ROWS) begin
			return RW'(MAX_ROWS);
		end
		return RW'(v);
	endfunction

endpackage

[rtl/core/integral_image_box_sum.sv]
`timescale 1ns / 1ps

// Summed-area table builder with rectangle box-sum queries. Pixel words
// (opcode 0) arrive in raster order and are folded into a table held in one
// single-port-read, single-port-write synchronous memory: each entry is the
// running sum of its row plus the entry directly above it. A pixel first
// reads the entry above as it is accepted, then writes the new entry. A query
// word (opcode 1) names an inclusive rectangle; the block reads the four
// corner entries one after another through the single read port, then loads
// the sum into the output register, waiting while that register is still
// held by a stalled earlier result. A rectangle that is inverted or reaches
// past the active image size returns box_sum 0 with bad_rect set. Queries
// produce one result word each; pixels produce none. A new word is taken
// only once the previous one has finished, but a result waiting in the
// output register does not hold back pixel words. The table has no reset:
// reading an entry that was never written gives an undefined sum. img_width
// and img_height are written through the cfg port, and only while the block
// is idle: the user must keep to this, as the block does not enforce it.
// Zero acts as one and values above the table size act as the table size.
module integral_image_box_sum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  iibs_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output iibs_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic                           cfg_idx,
	input  logic [iibs_pkg::SIZE_W-1:0]    cfg_data
);

	// Configuration and frame position.
	logic [iibs_pkg::SIZE_W-1:0]   width_q;
	logic [iibs_pkg::SIZE_W-1:0]   height_q;
	logic [iibs_pkg::CW-1:0]       w_eff;
	logic [iibs_pkg::RW-1:0]       h_eff;
	logic [iibs_pkg::COL_W-1:0]    col_q;
	logic [iibs_pkg::ROW_W-1:0]    row_q;
	logic [iibs_pkg::ROWSUM_W-1:0] rowsum_q;
	logic [iibs_pkg::CW-1:0]       col_inc;
	logic [iibs_pkg::RW-1:0]       row_inc;

	// Sequencer.
	iibs_pkg::state_t state_q;
	iibs_pkg::state_t state_nxt;
	logic [1:0]       step_q;
	logic             accept;
	logic             is_pixel;
	logic             bad;
	logic             res_load;

	// Memory ports.
	logic                        rd_en;
	logic [iibs_pkg::ADDR_W-1:0] rd_addr;
	logic [iibs_pkg::SUM_W-1:0]  rd_data_q;
	logic                        wr_en;
	logic [iibs_pkg::ADDR_W-1:0] wr_addr_q;
	logic [iibs_pkg::SUM_W-1:0]  wr_data;
	logic [iibs_pkg::SUM_W-1:0]  mem [iibs_pkg::DEPTH];

	// Per-word payload.
	logic                       above_vld_q;
	logic [7:0]                 l_q;
	logic [7:0]                 t_q;
	logic [7:0]                 r_q;
	logic [7:0]                 b_q;
	logic                       bad_q;
	logic [iibs_pkg::SUM_W-1:0] acc_q;
	logic [iibs_pkg::SUM_W-1:0] acc_nxt;
	logic                       term_en;
	logic                       term_neg;
	logic [1:0]                 rd_step;
	logic [7:0]                 sel_l;
	logic [7:0]                 sel_t;
	logic [7:0]                 sel_r;
	logic [7:0]                 sel_b;

	// Output register.
	logic              res_valid_q;
	iibs_pkg::result_t res_q;

	assign w_eff    = iibs_pkg::clamp_cols(width_q);
	assign h_eff    = iibs_pkg::clamp_rows(height_q);
	assign accept   = item_valid && !item_stall;
	assign is_pixel = (item.opcode == iibs_pkg::OP_PIXEL);
	assign res_load = (state_q == iibs_pkg::ST_DONE) && (!res_valid_q || !result_stall);

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign bad = (item.left_col > item.right_col) || (item.top_row > item.bottom_row)
		|| (32'(item.right_col) >= 32'(w_eff)) || (32'(item.bottom_row) >= 32'(h_eff));

	assign col_inc = iibs_pkg::CW'(col_q) + iibs_pkg::CW'(1);
	assign row_inc = iibs_pkg::RW'(row_q) + iibs_pkg::RW'(1);

	// New entry: this row's running sum plus the entry above, if there is one.
	assign wr_data = iibs_pkg::SUM_W'(rowsum_q) + (above_vld_q ? rd_data_q : '0);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			iibs_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_pixel) begin
						state_nxt = iibs_pkg::ST_PIX_WR;
					end else if (bad) begin
						state_nxt = iibs_pkg::ST_DONE;
					end else begin
						state_nxt = iibs_pkg::ST_QRY;
					end
				end
			end
			iibs_pkg::ST_PIX_WR: begin
				state_nxt = iibs_pkg::ST_IDLE;
			end
			iibs_pkg::ST_QRY: begin
				if (step_q == 2'd3) begin
					state_nxt = iibs_pkg::ST_DONE;
				end
			end
			iibs_pkg::ST_DONE: begin
				if (res_load) begin
					state_nxt = iibs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = iibs_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: handshake and memory port control.
	always_comb begin
		item_stall = 1'b1;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		rd_step    = 2'd0;
		case (state_q)
			iibs_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				rd_en      = item_valid && (is_pixel ? (row_q != '0) : !bad);
			end
			iibs_pkg::ST_PIX_WR: begin
				wr_en = 1'b1;
			end
			iibs_pkg::ST_QRY: begin
				rd_en   = (step_q != 2'd3);
				rd_step = step_q + 2'd1;
			end
			iibs_pkg::ST_DONE: begin
				item_stall = 1'b1;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// Corner reads in order: (b,r) +, (b,l-1) -, (t-1,r) -, (t-1,l-1) +.
	// The first read is issued straight from the incoming word.
	always_comb begin
		sel_l = (state_q == iibs_pkg::ST_IDLE) ? item.left_col : l_q;
		sel_t = (state_q == iibs_pkg::ST_IDLE) ? item.top_row : t_q;
		sel_r = (state_q == iibs_pkg::ST_IDLE) ? item.right_col : r_q;
		sel_b = (state_q == iibs_pkg::ST_IDLE) ? item.bottom_row : b_q;
		if ((state_q == iibs_pkg::ST_IDLE) && is_pixel) begin
			rd_addr = iibs_pkg::addr_of(int'(row_q - iibs_pkg::ROW_W'(1)), int'(col_q));
		end else begin
			case (rd_step)
				2'd0: rd_addr = iibs_pkg::addr_of(int'(sel_b), int'(sel_r));
				2'd1: rd_addr = iibs_pkg::addr_of(int'(sel_b), int'(sel_l - 8'd1));
				2'd2: rd_addr = iibs_pkg::addr_of(int'(sel_t - 8'd1), int'(sel_r));
				2'd3: rd_addr = iibs_pkg::addr_of(int'(sel_t - 8'd1), int'(sel_l - 8'd1));
				default: rd_addr = '0;
			endcase
		end
	end

	// Fold the corner that has just come back from memory into the sum.
	// Corners that fall off the top or left edge are skipped.
	always_comb begin
		case (step_q)
			2'd0: begin
				term_en  = 1'b1;
				term_neg = 1'b0;
			end
			2'd1: begin
				term_en  = (l_q != '0);
				term_neg = 1'b1;
			end
			2'd2: begin
				term_en  = (t_q != '0);
				term_neg = 1'b1;
			end
			2'd3: begin
				term_en  = (l_q != '0) && (t_q != '0);
				term_neg = 1'b0;
			end
			default: begin
				term_en  = 1'b0;
				term_neg = 1'b0;
			end
		endcase
		if (!term_en) begin
			acc_nxt = acc_q;
		end else if (term_neg) begin
			acc_nxt = acc_q - rd_data_q;
		end else begin
			acc_nxt = acc_q + rd_data_q;
		end
	end

	// Table memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iibs_pkg::ST_IDLE;
			step_q      <= 2'd0;
			width_q     <= iibs_pkg::SIZE_RST;
			height_q    <= iibs_pkg::SIZE_RST;
			col_q       <= '0;
			row_q       <= '0;
			rowsum_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_idx)
					iibs_pkg::REG_WIDTH:  width_q  <= cfg_data;
					iibs_pkg::REG_HEIGHT: height_q <= cfg_data;
					default: width_q <= width_q;
				endcase
			end
			if (accept) begin
				step_q <= 2'd0;
			end else if (state_q == iibs_pkg::ST_QRY) begin
				step_q <= step_q + 2'd1;
			end
			if (accept && is_pixel) begin
				rowsum_q <= ((col_q == '0) ? '0 : rowsum_q) + iibs_pkg::ROWSUM_W'(item.pixel);
				if (col_inc >= w_eff) begin
					col_q <= '0;
					if (row_inc >= h_eff) begin
						row_q <= '0;
					end else begin
						row_q <= iibs_pkg::ROW_W'(row_inc);
					end
				end else begin
					col_q <= iibs_pkg::COL_W'(col_inc);
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			l_q         <= item.left_col;
			t_q         <= item.top_row;
			r_q         <= item.right_col;
			b_q         <= item.bottom_row;
			bad_q       <= bad;
			acc_q       <= '0;
			above_vld_q <= (row_q != '0);
			wr_addr_q   <= iibs_pkg::addr_of(int'(row_q), int'(col_q));
		end else if (state_q == iibs_pkg::ST_QRY) begin
			acc_q <= acc_nxt;
		end
		if (res_load) begin
			res_q.box_sum  <= bad_q ? '0 : acc_q;
			res_q.bad_rect <= bad_q;
		end
	end

	// The single memory never reads and writes in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && wr_en))
		else $error("table read and write collide");

	// An accepted pixel is written back in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pixel) |=> (state_q == iibs_pkg::ST_PIX_WR) && wr_en)
		else $error("pixel write-back missing");

	// A new result only appears after the sequencer finished a query.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == iibs_pkg::ST_DONE))
		else $error("result without a finished query");

	// A rejected rectangle always reports a zero sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.bad_rect) |-> (res_q.box_sum == '0))
		else $error("bad rectangle with nonzero sum");

endmodule
